[design/wts_pkg.sv]
// shared constants, character classes and controller/datapath interface types
`default_nettype none

package wts_pkg;

	localparam int WORD_BUF_LEN = 32;
	localparam int IDX_W        = $clog2(WORD_BUF_LEN);
	localparam int LEN_W        = 6;
	localparam int CNT_W        = 32;

	localparam logic [7:0] CHAR_NL = 8'h0a;

	// datapath commands from the controller
	typedef struct packed {
		logic accept;
		logic load_char;
		logic load_mark;
		logic last_flag;
	} cmd_t;

	// datapath status toward the controller
	typedef struct packed {
		logic emit_req;
		logic mark_req;
		logic char_last;
	} sts_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

`default_nettype wire

[design/word_tokenizer_stream_unit.sv]
// word tokenizer top level: controller and datapath
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  character, end_of_input
//  out      output     out_valid/out_stall  word_char, word_length, word_line,
//                                           word_index, last, input_done
//  cfg      input      cfg_valid/cfg_ready  cfg_data (max_word_length)
//
// an item that finishes no word, and is not the end of input, is taken back to back
// an item that finishes a word stalls the input while its characters are sent, then
// the end-of-input marker if it has one; the single output register sets this pace
// out_stall holds the output register and, through it, the emission sequence
// arst_n resets scan state, counters and max length (32); the word buffer is not cleared
`default_nettype none

module word_tokenizer_stream_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 character,
	input  logic                       end_of_input,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 word_char,
	output logic [wts_pkg::LEN_W-1:0]  word_length,
	output logic [wts_pkg::CNT_W-1:0]  word_line,
	output logic [wts_pkg::CNT_W-1:0]  word_index,
	output logic                       last,
	output logic                       input_done,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [wts_pkg::LEN_W-1:0]  cfg_data
);
	import wts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	wts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	wts_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.character    (character),
		.end_of_input (end_of_input),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.word_char    (word_char),
		.word_length  (word_length),
		.word_line    (word_line),
		.word_index   (word_index),
		.last         (last),
		.input_done   (input_done)
	);

endmodule

`default_nettype wire

[design/wts_dpath.sv]
// tokenizer datapath: scan state, word buffer, counters and output register
`default_nettype none

module wts_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  character,
	input  logic                        end_of_input,
	input  logic                        cfg_we,
	input  logic [wts_pkg::LEN_W-1:0]   cfg_data,
	input  wts_pkg::cmd_t               cmd,
	output wts_pkg::sts_t               sts,
	output logic [7:0]                  word_char,
	output logic [wts_pkg::LEN_W-1:0]   word_length,
	output logic [wts_pkg::CNT_W-1:0]   word_line,
	output logic [wts_pkg::CNT_W-1:0]   word_index,
	output logic                        last,
	output logic                        input_done
);
	import wts_pkg::*;

	typedef enum logic [1:0] {
		MODE_ELIGIBLE = 2'd0,
		MODE_BLOCKED  = 2'd1,
		MODE_IN_WORD  = 2'd2,
		MODE_FINISHED = 2'd3
	} mode_t;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_BUF_LEN);

	mode_t              mode_q, mode_n;
	logic [LEN_W-1:0]   len_q, len_n, len_inc;
	logic [CNT_W-1:0]   line_q, line_n, line_inc;
	logic [CNT_W-1:0]   start_line_q, start_n;
	logic [CNT_W-1:0]   words_q;
	logic [LEN_W-1:0]   max_len_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [7:0]         store_q [WORD_BUF_LEN];
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               emit, mark;
	logic               sp, an;

	assign sp       = is_space(character);
	assign an       = is_alnum(character);
	assign len_inc  = len_q + LEN_W'(1);
	assign line_inc = (character == CHAR_NL && line_q != '1) ? line_q + CNT_W'(1) : line_q;

	always_comb begin
		mode_n  = mode_q;
		len_n   = len_q;
		line_n  = line_q;
		start_n = start_line_q;
		wr_en   = 1'b0;
		wr_idx  = '0;
		emit    = 1'b0;
		mark    = 1'b0;
		priority if (mode_q == MODE_FINISHED) begin
			mode_n = mode_q;
		end else if (end_of_input) begin
			emit   = (mode_q == MODE_IN_WORD);
			mark   = 1'b1;
			mode_n = MODE_FINISHED;
		end else if (mode_q == MODE_IN_WORD) begin
			if (sp) begin
				line_n = line_inc;
				emit   = 1'b1;
				mode_n = MODE_ELIGIBLE;
			end else begin
				if (len_q < MAX_LEN) begin
					wr_en  = 1'b1;
					wr_idx = len_q[IDX_W-1:0];
					len_n  = len_inc;
				end
				if (len_n >= max_len_q || len_n >= MAX_LEN) begin
					emit   = 1'b1;
					mode_n = MODE_ELIGIBLE;
				end
			end
		end else if (sp) begin
			line_n = line_inc;
			mode_n = MODE_ELIGIBLE;
		end else if (!an) begin
			mode_n = MODE_BLOCKED;
		end else if (mode_q == MODE_ELIGIBLE) begin
			wr_en   = 1'b1;
			wr_idx  = '0;
			len_n   = LEN_W'(1);
			start_n = line_q;
			if (max_len_q <= LEN_W'(1)) begin
				emit   = 1'b1;
				mode_n = MODE_ELIGIBLE;
			end else begin
				mode_n = MODE_IN_WORD;
			end
		end else begin
			mode_n = mode_q;
		end
	end

	assign sts.emit_req  = emit;
	assign sts.mark_req  = mark;
	assign sts.char_last = (LEN_W'(rd_idx_q) + LEN_W'(1) == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ELIGIBLE;
			len_q        <= '0;
			line_q       <= CNT_W'(1);
			start_line_q <= CNT_W'(1);
			words_q      <= '0;
			rd_idx_q     <= '0;
		end else if (cmd.accept) begin
			mode_q       <= mode_n;
			len_q        <= len_n;
			line_q       <= line_n;
			start_line_q <= start_n;
		end else if (cmd.load_char) begin
			if (sts.char_last) begin
				// word fully sent out
				rd_idx_q <= '0;
				len_q    <= '0;
				if (words_q != '1) begin
					words_q <= words_q + CNT_W'(1);
				end
			end else begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN;
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				max_len_q <= LEN_W'(1);
			end else if (cfg_data > MAX_LEN) begin
				max_len_q <= MAX_LEN;
			end else begin
				max_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			store_q[wr_idx] <= character;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			word_char   <= store_q[rd_idx_q];
			word_length <= len_q;
			word_line   <= start_line_q;
			word_index  <= words_q;
			last        <= cmd.last_flag;
			input_done  <= 1'b0;
		end else if (cmd.load_mark) begin
			word_char   <= '0;
			word_length <= '0;
			word_line   <= line_q;
			word_index  <= words_q;
			last        <= 1'b1;
			input_done  <= 1'b1;
		end
	end

	a_char_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_char |-> (LEN_W'(rd_idx_q) < len_q))
		else $error("word character read beyond stored length");

	a_mark_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mark |-> (mode_q == MODE_FINISHED))
		else $error("end marker sent while scan not finished");

endmodule

`default_nettype wire

[design/wts_ctrl.sv]
// tokenizer controller: input acceptance, word emission sequence, output valid
`default_nettype none

module wts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  wts_pkg::sts_t  sts,
	output wts_pkg::cmd_t  cmd
);
	import wts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EMIT = 3'b010,
		S_MARK = 3'b100
	} state_t;

	state_t state_q, state_n;
	logic   mark_pend_q, mark_n;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		mark_n  = mark_pend_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.emit_req) begin
						state_n = S_EMIT;
						mark_n  = sts.mark_req;
					end else if (sts.mark_req) begin
						state_n = S_MARK;
					end
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.load_char = 1'b1;
					// only the final character closes the item, unless the marker follows
					cmd.last_flag = !mark_pend_q && sts.char_last;
					if (sts.char_last) begin
						state_n = mark_pend_q ? S_MARK : S_IDLE;
					end
				end
			end
			S_MARK: begin
				if (slot_free) begin
					cmd.load_mark = 1'b1;
					mark_n        = 1'b0;
					state_n       = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mark_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			mark_pend_q <= mark_n;
			if (cmd.load_char || cmd.load_mark) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idle_no_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mark_pend_q)
		else $error("pending end marker left behind in idle");

	a_emit_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.emit_req) |=> (state_q == S_EMIT))
		else $error("finished word not sent out");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_char, cmd.load_mark}))
		else $error("conflicting datapath commands");

endmodule

`default_nettype wire
